FILE: rtl/bmh_pkg.sv
// Shared types and codes for the binary min-heap core.
// Used by bmh_ctrl, bmh_dpath and binary_min_heap_core; no dependencies.
`default_nettype none

package bmh_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned HandleW = 9;
  localparam int unsigned FillW   = 10;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic               action;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0]    out_key;
    logic [HandleW-1:0] out_handle;
    logic [1:0]         status;
    logic [FillW-1:0]   fill;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_INIT,
    OP_POP_INIT,
    OP_REJECT_FULL,
    OP_REJECT_EMPTY,
    OP_UP_CHK,
    OP_UP_CMP,
    OP_POP_ROOT,
    OP_POP_LAST,
    OP_DN_L,
    OP_DN_R,
    OP_DN_CMP,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic cnt_zero;
    logic up_swap;
    logic left_in;
    logic dn_swap;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/bmh_dpath.sv
// Datapath of the binary min-heap core: entry memory, count, sift registers, result.
// Depends on bmh_pkg; driven by bmh_ctrl through cmd_t, reports through sts_t.
`default_nettype none

module bmh_dpath #(
  parameter int unsigned DEPTH = 512
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire bmh_pkg::cmd_t      cmd_i,
  input  wire bmh_pkg::in_item_t  in_item_i,
  output bmh_pkg::sts_t      sts_o,
  output bmh_pkg::out_item_t out_item_o
);
  import bmh_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = AW + 2;

  entry_t              mem_q [DEPTH];
  entry_t              rdata_q;
  logic   [CW-1:0]     cnt_q, cnt_d;
  logic   [AW-1:0]     pos_q, pos_d;
  entry_t              ent_q, ent_d;
  entry_t              lft_q, lft_d;
  logic   [KeyW-1:0]   res_key_q, res_key_d;
  logic   [HandleW-1:0] res_handle_q, res_handle_d;
  status_e             res_status_q, res_status_d;
  out_item_t           out_q, out_d;

  logic   [AW-1:0]     parent;
  logic   [XW-1:0]     lidx, ridx, cnt_x;
  logic                right_in, lft_less, r_less;
  logic   [KeyW-1:0]   best_key;
  entry_t              child;
  logic   [XW-1:0]     child_idx;

  logic                re, we;
  logic   [AW-1:0]     raddr, waddr;
  entry_t              wdata;

  assign parent    = AW'((pos_q - AW'(1)) >> 1);
  assign lidx      = {1'b0, pos_q, 1'b1};
  assign ridx      = lidx + XW'(1);
  assign cnt_x     = XW'(cnt_q);
  assign right_in  = ridx < cnt_x;
  assign lft_less  = lft_q.key < ent_q.key;
  assign best_key  = lft_less ? lft_q.key : ent_q.key;
  assign r_less    = right_in && (rdata_q.key < best_key);
  assign child     = r_less ? rdata_q : lft_q;
  assign child_idx = r_less ? ridx : lidx;

  always_comb begin
    sts_o          = '0;
    sts_o.full     = cnt_q == CW'(DEPTH);
    sts_o.empty    = cnt_q == '0;
    sts_o.pos_root = pos_q == '0;
    sts_o.cnt_zero = cnt_q == '0;
    sts_o.up_swap  = rdata_q.key > ent_q.key;
    sts_o.left_in  = lidx < cnt_x;
    sts_o.dn_swap  = lft_less || r_less;
  end

  always_comb begin
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    ent_d        = ent_q;
    lft_d        = lft_q;
    res_key_d    = res_key_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    re           = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = ent_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_INS_INIT: begin
        ent_d        = '{key: in_item_i.key, handle: in_item_i.handle};
        pos_d        = AW'(cnt_q);
        cnt_d        = cnt_q + CW'(1);
        res_key_d    = '0;
        res_handle_d = '0;
        res_status_d = STATUS_OK;
      end
      OP_POP_INIT: begin
        cnt_d        = cnt_q - CW'(1);
        re           = 1'b1;
        raddr        = '0;
        res_status_d = STATUS_OK;
      end
      OP_REJECT_FULL: begin
        res_key_d    = '0;
        res_handle_d = '0;
        res_status_d = STATUS_FULL;
      end
      OP_REJECT_EMPTY: begin
        res_key_d    = '0;
        res_handle_d = '0;
        res_status_d = STATUS_EMPTY;
      end
      OP_UP_CHK: begin
        if (sts_o.pos_root) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = parent;
        end
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (sts_o.up_swap) begin
          wdata = rdata_q;
          pos_d = parent;
        end
      end
      OP_POP_ROOT: begin
        res_key_d    = rdata_q.key;
        res_handle_d = rdata_q.handle;
        re           = 1'b1;
        raddr        = AW'(cnt_q);
      end
      OP_POP_LAST: begin
        ent_d = rdata_q;
        pos_d = '0;
      end
      OP_DN_L: begin
        if (sts_o.left_in) begin
          re    = 1'b1;
          raddr = AW'(lidx);
        end else begin
          we = 1'b1;
        end
      end
      OP_DN_R: begin
        lft_d = rdata_q;
        re    = 1'b1;
        raddr = AW'(ridx);
      end
      OP_DN_CMP: begin
        we = 1'b1;
        if (sts_o.dn_swap) begin
          wdata = child;
          pos_d = AW'(child_idx);
        end
      end
      OP_LOAD_OUT: begin
        out_d.out_key    = res_key_q;
        out_d.out_handle = res_handle_q;
        out_d.status     = res_status_q;
        out_d.fill       = FillW'(cnt_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    ent_q        <= ent_d;
    lft_q        <= lft_d;
    res_key_q    <= res_key_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/bmh_ctrl.sv
// Controller of the binary min-heap core: sequences insert and pop transactions.
// Depends on bmh_pkg; commands bmh_dpath through cmd_t and reads sts_t.
`default_nettype none

module bmh_ctrl (
  input  wire           logic clk_i,
  input  wire           logic rst_ni,
  input  wire           logic in_valid_i,
  input  wire           logic in_action_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire           logic out_ready_i,
  input  wire bmh_pkg::sts_t sts_i,
  output bmh_pkg::cmd_t cmd_o
);
  import bmh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_CHK   = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_ROOT = 9'b000001000,
    S_POP_LAST = 9'b000010000,
    S_DN_L     = 9'b000100000,
    S_DN_R     = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_DONE;
          if (in_action_i == ACT_INSERT) begin
            if (sts_i.full) begin
              cmd_o.op = OP_REJECT_FULL;
            end else begin
              cmd_o.op = OP_INS_INIT;
              state_d  = S_UP_CHK;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.op = OP_REJECT_EMPTY;
            end else begin
              cmd_o.op = OP_POP_INIT;
              state_d  = S_POP_ROOT;
            end
          end
        end
      end
      S_UP_CHK: begin
        cmd_o.op = OP_UP_CHK;
        state_d  = sts_i.pos_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.op = OP_UP_CMP;
        state_d  = sts_i.up_swap ? S_UP_CHK : S_DONE;
      end
      S_POP_ROOT: begin
        cmd_o.op = OP_POP_ROOT;
        state_d  = sts_i.cnt_zero ? S_DONE : S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd_o.op = OP_POP_LAST;
        state_d  = S_DN_L;
      end
      S_DN_L: begin
        cmd_o.op = OP_DN_L;
        state_d  = sts_i.left_in ? S_DN_R : S_DONE;
      end
      S_DN_R: begin
        cmd_o.op = OP_DN_R;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.op = OP_DN_CMP;
        state_d  = sts_i.dn_swap ? S_DN_L : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/binary_min_heap_core.sv
// Binary min-heap priority queue of DEPTH entries, each a 32-bit key and a 9-bit
// handle. An insert places the new entry at the end and sifts it up toward the root;
// a pop returns the root, moves the last entry to the root and sifts it down,
// and needs no sift when it takes the last entry. An insert on a full heap or a
// pop on an empty one is answered with STATUS_FULL or STATUS_EMPTY and leaves the
// heap unchanged. The sift is paced by the single read port of the entry memory,
// through which it reads one entry at a time. One transaction is worked at a time;
// a new one is taken while the previous result waits in the output register.
// Top level; instantiates bmh_ctrl and bmh_dpath, uses bmh_pkg.
`default_nettype none

module binary_min_heap_core #(
  parameter int unsigned DEPTH = 512
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic               in_ready_o,
  input  wire bmh_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  wire                logic out_ready_i,
  output bmh_pkg::out_item_t out_item_o
);
  import bmh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmh_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb_binary_min_heap_core.sv
// Self-checking testbench for binary_min_heap_core: inserts and pops go in as
// transactions, and each result is checked against an in-bench heap model.
// Depends on bmh_pkg and binary_min_heap_core.
`timescale 1ns / 1ps

module tb_binary_min_heap_core;
  import bmh_pkg::*;

  localparam int unsigned HeapDepth     = 512;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  entry_t      model_heap [HeapDepth];
  int unsigned model_count;
  out_item_t   heap_results_due [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned rx_cycle;
  int unsigned rx_stall;

  binary_min_heap_core #(
    .DEPTH(HeapDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #5 clk = ~clk;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t             = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = t;
  endfunction

  function automatic out_item_t heap_predict(in_item_t it);
    out_item_t   res;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    res = '0;
    res.status = STATUS_OK;
    if (it.action == ACT_INSERT) begin
      if (model_count >= HeapDepth) begin
        res.status = STATUS_FULL;
      end else begin
        model_heap[model_count] = '{key: it.key, handle: it.handle};
        pos = model_count;
        model_count++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!(model_heap[up].key > model_heap[pos].key)) break;
          swap_slots(up, pos);
          pos = up;
        end
      end
    end else begin
      if (model_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out_key    = model_heap[0].key;
        res.out_handle = model_heap[0].handle;
        model_count--;
        if (model_count > 0) begin
          model_heap[0] = model_heap[model_count];
          pos = 0;
          forever begin
            best = pos;
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            if (lc < model_count && model_heap[lc].key < model_heap[best].key) best = lc;
            if (rc < model_count && model_heap[rc].key < model_heap[best].key) best = rc;
            if (best == pos) break;
            swap_slots(best, pos);
            pos = best;
          end
        end
      end
    end
    res.fill = model_count[FillW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t ERROR %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic send_op(logic act, logic [KeyW-1:0] key, logic [HandleW-1:0] handle);
    in_item_t it;
    it = '{action: act, key: key, handle: handle};
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    heap_results_due.insert(heap_results_due.size(), heap_predict(it));
  endtask

  // hold off new transactions until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (heap_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_pop();
    send_op(ACT_POP, 32'hFFFF_FFFF, 9'h1FF);
    send_op(ACT_POP, 32'h0, 9'h0);
  endtask

  task automatic test_extremes();
    send_op(ACT_INSERT, 32'hFFFF_FFFF, 9'h1FF);
    send_op(ACT_INSERT, 32'h0, 9'h0);
    send_op(ACT_INSERT, 32'hFFFF_FFFF, 9'h0);
    send_op(ACT_INSERT, 32'h0, 9'h1FF);
    send_op(ACT_INSERT, 32'h8000_0000, 9'h0AA);
    repeat (5) send_op(ACT_POP, 32'h5555_5555, 9'h155);
  endtask

  task automatic test_ties();
    send_op(ACT_INSERT, 32'd7, 9'd1);
    send_op(ACT_INSERT, 32'd7, 9'd2);
    send_op(ACT_INSERT, 32'd7, 9'd3);
    send_op(ACT_INSERT, 32'd7, 9'd4);
    send_op(ACT_INSERT, 32'd2, 9'd5);
    send_op(ACT_INSERT, 32'd7, 9'd6);
    repeat (6) send_op(ACT_POP, $urandom, 9'($urandom));
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned ins_pct;
    for (int unsigned i = 0; i < n; i++) begin
      ins_pct = (i < n / 2) ? 70 : 35;
      if ($urandom_range(0, 99) < ins_pct)
        send_op(ACT_INSERT, rand_key(), 9'($urandom_range(0, 511)));
      else
        send_op(ACT_POP, $urandom, 9'($urandom));
    end
  endtask

  task automatic test_fill_to_full();
    while (model_count < HeapDepth)
      send_op(ACT_INSERT, rand_key(), 9'($urandom_range(0, 511)));
    repeat (3) send_op(ACT_INSERT, rand_key(), 9'($urandom_range(0, 511)));
  endtask

  task automatic test_drain_to_empty();
    while (model_count > 0) send_op(ACT_POP, $urandom, 9'($urandom));
    repeat (3) send_op(ACT_POP, $urandom, 9'($urandom));
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    if ((rx_cycle % 600) < 150) begin
      out_ready <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (heap_results_due.size() == 0) begin
        report_mismatch("result with none due", 64'(out_item), 64'h0);
      end else begin
        want = heap_results_due.pop_front();
        if (out_item.out_key !== want.out_key)
          report_mismatch("out_key", 64'(out_item.out_key), 64'(want.out_key));
        if (out_item.out_handle !== want.out_handle)
          report_mismatch("out_handle", 64'(out_item.out_handle), 64'(want.out_handle));
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
        if (out_item.fill !== want.fill)
          report_mismatch("fill", 64'(out_item.fill), 64'(want.fill));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("binary_min_heap_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    model_count    = 0;
    mismatch_count = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    rx_cycle       = 0;
    rx_stall       = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_pop();
    test_extremes();
    test_ties();
    wait_drained();
    test_random_mix(60);
    test_fill_to_full();
    wait_drained();
    test_drain_to_empty();
    wait_drained();
    test_random_mix(40);
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (heap_results_due.size() != 0)
      report_mismatch("results left due", 64'(heap_results_due.size()), 64'h0);
    if (mismatch_count == 0) begin
      $display("binary_min_heap_core regression: pass");
    end else begin
      $display("binary_min_heap_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bmh_pkg.sv
rtl/bmh_dpath.sv
rtl/bmh_ctrl.sv
rtl/binary_min_heap_core.sv
dv/tb_binary_min_heap_core.sv
